/* rtl/key_event_scancode_sequencer_macros.svh */
// assertion macros for the key event scan code sequencer checker
// no dependencies; included by files that carry assertions
`ifndef KEY_EVENT_SCANCODE_SEQUENCER_MACROS_SVH
`define KEY_EVENT_SCANCODE_SEQUENCER_MACROS_SVH

// same-cycle implication, off during reset
`define KESS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kess: implication failed");

// next-cycle implication, off during reset
`define KESS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kess: next-cycle check failed");

// condition that holds while reset is applied
`define KESS_ASSERT_IN_RESET(label, clk, rst_n, cons) \
    label: assert property (@(posedge clk) (!rst_n) |-> (cons)) \
        else $error("kess: reset check failed");

`endif

/* rtl/kess_pkg.sv */
// shared types, constants and scan code lookup for the key event sequencer
// no dependencies
package kess_pkg;

    localparam int KEY_W     = 16;
    localparam int MOD_W     = 9;
    localparam int NUM_SLOTS = 12;
    localparam int SLOT_W    = 4;

    // modifier flag bit positions
    localparam int MOD_SHIFT = 0;
    localparam int MOD_CTRL  = 1;
    localparam int MOD_ALT   = 2;
    localparam int MOD_SUPER = 3;
    localparam int MOD_HYPER = 4;
    localparam int MOD_META  = 5;
    localparam int MOD_FAKE  = 6;
    localparam int MOD_UP    = 7;
    localparam int MOD_DOWN  = 8;

    // high-byte prefixes that imply a modifier
    localparam logic [7:0] PFX_CTRL  = 8'h1d;
    localparam logic [7:0] PFX_SHIFT = 8'h2a;
    localparam logic [7:0] PFX_ALT   = 8'h38;
    localparam logic [7:0] PFX_SUPER = 8'h5b;

    // special keys and rewrites
    localparam logic [KEY_W-1:0] KEY_SYSRQ     = 16'he037;
    localparam logic [KEY_W-1:0] KEY_PAUSE     = 16'he11d;
    localparam logic [KEY_W-1:0] KEY_ALT_SYSRQ = 16'h0054;
    localparam logic [KEY_W-1:0] KEY_CTRL_BRK  = 16'he046;

    // modifier scan codes
    localparam logic [KEY_W-1:0] SC_SUPER = 16'he05b;
    localparam logic [KEY_W-1:0] SC_CTRL  = 16'h001d;
    localparam logic [KEY_W-1:0] SC_ALT   = 16'h0038;
    localparam logic [KEY_W-1:0] SC_SHIFT = 16'h002a;
    localparam logic [KEY_W-1:0] SC_FAKE  = 16'he02a;

    // emission slots in output order
    localparam logic [SLOT_W-1:0] SL_P_SUPER = 4'd0;
    localparam logic [SLOT_W-1:0] SL_P_CTRL  = 4'd1;
    localparam logic [SLOT_W-1:0] SL_P_ALT   = 4'd2;
    localparam logic [SLOT_W-1:0] SL_P_SHIFT = 4'd3;
    localparam logic [SLOT_W-1:0] SL_P_FAKE  = 4'd4;
    localparam logic [SLOT_W-1:0] SL_P_KEY   = 4'd5;
    localparam logic [SLOT_W-1:0] SL_R_KEY   = 4'd6;
    localparam logic [SLOT_W-1:0] SL_R_FAKE  = 4'd7;
    localparam logic [SLOT_W-1:0] SL_R_SHIFT = 4'd8;
    localparam logic [SLOT_W-1:0] SL_R_ALT   = 4'd9;
    localparam logic [SLOT_W-1:0] SL_R_CTRL  = 4'd10;
    localparam logic [SLOT_W-1:0] SL_R_SUPER = 4'd11;

    localparam int NUM_PRESS = 6;

    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

    typedef struct packed {
        logic [KEY_W-1:0] code;
        slot_mask_t       mask;
    } desc_t;

    function automatic logic [KEY_W-1:0] slot_code(input logic [SLOT_W-1:0] slot,
                                                   input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] sc;
        case (slot)
            SL_P_SUPER, SL_R_SUPER: sc = SC_SUPER;
            SL_P_CTRL,  SL_R_CTRL:  sc = SC_CTRL;
            SL_P_ALT,   SL_R_ALT:   sc = SC_ALT;
            SL_P_SHIFT, SL_R_SHIFT: sc = SC_SHIFT;
            SL_P_FAKE,  SL_R_FAKE:  sc = SC_FAKE;
            SL_P_KEY,   SL_R_KEY:   sc = key;
            default:                sc = '0;
        endcase
        return sc;
    endfunction

endpackage

/* rtl/kess_front.sv */
// front end: accepts key event beats, applies modifier rules, builds slot mask
// depends on kess_pkg
module kess_front (
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [31:0]            s_axis_tdata,
    input  logic                   auto_release,
    output logic                   push_valid,
    input  logic                   push_ready,
    output kess_pkg::desc_t        push_desc
);

    logic [kess_pkg::KEY_W-1:0] code;
    logic [kess_pkg::MOD_W-1:0] mods;
    logic                       press_en;
    logic                       rel_en;
    logic                       sup;
    logic                       has_key;
    kess_pkg::slot_mask_t       mask;

    always_comb
    begin
        code = s_axis_tdata[kess_pkg::KEY_W-1:0];
        mods = s_axis_tdata[kess_pkg::KEY_W +: kess_pkg::MOD_W];

        case (code[15:8])
            kess_pkg::PFX_CTRL:  mods[kess_pkg::MOD_CTRL]  = 1'b1;
            kess_pkg::PFX_SHIFT: mods[kess_pkg::MOD_SHIFT] = 1'b1;
            kess_pkg::PFX_ALT:   mods[kess_pkg::MOD_ALT]   = 1'b1;
            kess_pkg::PFX_SUPER: mods[kess_pkg::MOD_SUPER] = 1'b1;
            default: ;
        endcase

        if (code == kess_pkg::KEY_SYSRQ)
        begin
            if (mods[kess_pkg::MOD_SHIFT] || mods[kess_pkg::MOD_CTRL])
            begin
                mods[kess_pkg::MOD_SHIFT] = 1'b0;
                mods[kess_pkg::MOD_CTRL]  = 1'b0;
            end
            else if (mods[kess_pkg::MOD_ALT])
            begin
                mods[kess_pkg::MOD_ALT] = 1'b0;
                code = kess_pkg::KEY_ALT_SYSRQ;
            end
            else
            begin
                mods[kess_pkg::MOD_FAKE] = 1'b1;
            end
        end
        else if (code == kess_pkg::KEY_PAUSE)
        begin
            if (mods[kess_pkg::MOD_CTRL])
            begin
                mods[kess_pkg::MOD_CTRL] = 1'b0;
                code = kess_pkg::KEY_CTRL_BRK;
            end
        end

        press_en = !(mods[kess_pkg::MOD_UP] && !mods[kess_pkg::MOD_DOWN]);
        rel_en   = auto_release || mods[kess_pkg::MOD_UP];
        sup      = mods[kess_pkg::MOD_SUPER] || mods[kess_pkg::MOD_HYPER]
                   || mods[kess_pkg::MOD_META];
        has_key  = (code != '0);

        mask = '0;
        mask[kess_pkg::SL_P_SUPER] = press_en && sup;
        mask[kess_pkg::SL_P_CTRL]  = press_en && mods[kess_pkg::MOD_CTRL];
        mask[kess_pkg::SL_P_ALT]   = press_en && mods[kess_pkg::MOD_ALT];
        mask[kess_pkg::SL_P_SHIFT] = press_en && mods[kess_pkg::MOD_SHIFT];
        mask[kess_pkg::SL_P_FAKE]  = press_en && mods[kess_pkg::MOD_FAKE];
        mask[kess_pkg::SL_P_KEY]   = press_en && has_key;
        mask[kess_pkg::SL_R_KEY]   = rel_en && has_key;
        mask[kess_pkg::SL_R_FAKE]  = rel_en && mods[kess_pkg::MOD_FAKE];
        mask[kess_pkg::SL_R_SHIFT] = rel_en && mods[kess_pkg::MOD_SHIFT];
        mask[kess_pkg::SL_R_ALT]   = rel_en && mods[kess_pkg::MOD_ALT];
        mask[kess_pkg::SL_R_CTRL]  = rel_en && mods[kess_pkg::MOD_CTRL];
        mask[kess_pkg::SL_R_SUPER] = rel_en && sup;
    end

    // events with nothing to emit are dropped here
    assign s_axis_tready  = push_ready;
    assign push_valid     = s_axis_tvalid && (mask != '0);
    assign push_desc.code = code;
    assign push_desc.mask = mask;

endmodule

/* rtl/kess_queue.sv */
// short descriptor queue between the front and back ends
// depends on kess_pkg
module kess_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  kess_pkg::desc_t push_desc,
    output logic            pop_valid,
    input  logic            pop,
    output kess_pkg::desc_t pop_desc
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    kess_pkg::desc_t entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_desc   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

/* rtl/kess_back.sv */
// back end: walks a descriptor's slot mask and emits one scan code beat per cycle unless the output stalls
// depends on kess_pkg
module kess_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pop_valid,
    output logic                       pop,
    input  kess_pkg::desc_t            pop_desc,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [kess_pkg::KEY_W-1:0] m_axis_tdata,
    output logic                       m_axis_tuser,
    output logic                       m_axis_tlast
);

    kess_pkg::slot_mask_t       mask_reg, mask_next;
    logic [kess_pkg::KEY_W-1:0] key_reg,  key_next;
    logic                       out_valid_reg, out_valid_next;
    logic [kess_pkg::KEY_W-1:0] out_code_reg;
    logic                       out_press_reg;
    logic                       out_last_reg;

    kess_pkg::slot_mask_t       pick;
    kess_pkg::slot_mask_t       remain;
    kess_pkg::slot_mask_t       mask_after;
    logic [kess_pkg::KEY_W-1:0] pick_code;
    logic                       advance;
    logic                       emit;

    always_comb
    begin
        pick      = mask_reg & (~mask_reg + 1'b1);
        remain    = mask_reg & ~pick;
        pick_code = '0;
        for (int i = 0; i < kess_pkg::NUM_SLOTS; i++)
        begin
            pick_code = pick_code | ({kess_pkg::KEY_W{pick[i]}}
                        & kess_pkg::slot_code(kess_pkg::SLOT_W'(i), key_reg));
        end
    end

    assign advance    = !out_valid_reg || m_axis_tready;
    assign emit       = advance && (mask_reg != '0);
    assign mask_after = emit ? remain : mask_reg;
    // load the next run as the current one hands out its final beat, or when none is loaded
    assign pop        = pop_valid && (mask_after == '0);

    always_comb
    begin
        mask_next      = mask_after;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (pop)
        begin
            mask_next = pop_desc.mask;
            key_next  = pop_desc.code;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (emit)
        begin
            out_code_reg  <= pick_code;
            out_press_reg <= |pick[kess_pkg::NUM_PRESS-1:0];
            out_last_reg  <= (remain == '0);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_code_reg;
    assign m_axis_tuser  = out_press_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

/* rtl/key_event_scancode_sequencer.sv */
// path: descriptor queue, back end slot mask register, then the output registers
// throughput: one scan code beat per cycle unless the output stalls; a run of 0 to 12
// beats per key event, runs back to back while queued; the back end's walk sets it
// input is taken while the descriptor queue has room (QUEUE_DEPTH entries)
// reset: asynchronous, active low; clears queue and output, auto_release returns to 1
// depends on kess_pkg, kess_front, kess_queue, kess_back
module key_event_scancode_sequencer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic        cfg_wdata,      // auto_release
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // key_code[15:0], modifier_flags[24:16], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // scan_code[15:0]
    output logic        m_axis_tuser,   // is_press
    output logic        m_axis_tlast    // last
);

    logic            auto_release_reg;
    logic            push_valid;
    logic            push_ready;
    kess_pkg::desc_t push_desc;
    logic            pop_valid;
    logic            pop;
    kess_pkg::desc_t pop_desc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_release_reg <= 1'b1;
        end
        else if (cfg_wen)
        begin
            auto_release_reg <= cfg_wdata;
        end
    end

    kess_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .auto_release  (auto_release_reg),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_desc     (push_desc)
    );

    kess_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_desc   (pop_desc)
    );

    kess_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop           (pop),
        .pop_desc      (pop_desc),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* rtl/kess_checker.sv */
// port-level checks for the key event scan code sequencer, bound to the top level
// depends on key_event_scancode_sequencer_macros.svh
`include "key_event_scancode_sequencer_macros.svh"

module kess_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // stalled output beat holds
    `KESS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // a zero scan code never goes out
    `KESS_ASSERT_IMPLY(a_no_zero_code, clk, rst_n, m_axis_tvalid, m_axis_tdata != 16'h0000)

    // no output beat while in reset
    `KESS_ASSERT_IN_RESET(a_reset_idle, clk, rst_n, !m_axis_tvalid)

endmodule

bind key_event_scancode_sequencer kess_checker u_kess_checker (.*);

/* tb/sv/key_event_scancode_sequencer_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for key_event_scancode_sequencer: directed and random key events,
// a scoreboard that predicts each scan code run, random stalls on both stream sides
// depends on kess_pkg and the key_event_scancode_sequencer rtl
module key_event_scancode_sequencer_tb;
    import kess_pkg::*;

    localparam int STALL_MAX  = 13;
    localparam int QUIET_WAIT = 16;
    localparam int HANG_LIMIT = 2000;
    localparam int PHASE_LEN  = 50;
    localparam int NUM_PHASES = 8;

    localparam logic [MOD_W-1:0] F_SHIFT = 9'b1 << MOD_SHIFT;
    localparam logic [MOD_W-1:0] F_CTRL  = 9'b1 << MOD_CTRL;
    localparam logic [MOD_W-1:0] F_ALT   = 9'b1 << MOD_ALT;
    localparam logic [MOD_W-1:0] F_SUPER = 9'b1 << MOD_SUPER;
    localparam logic [MOD_W-1:0] F_HYPER = 9'b1 << MOD_HYPER;
    localparam logic [MOD_W-1:0] F_META  = 9'b1 << MOD_META;
    localparam logic [MOD_W-1:0] F_FAKE  = 9'b1 << MOD_FAKE;
    localparam logic [MOD_W-1:0] F_UP    = 9'b1 << MOD_UP;
    localparam logic [MOD_W-1:0] F_DOWN  = 9'b1 << MOD_DOWN;
    localparam logic [MOD_W-1:0] F_ALL   = '1;

    typedef struct {
        bit               is_press;
        logic [KEY_W-1:0] scan_code;
        bit               last;
    } scan_beat_t;

    class scan_scoreboard;
        scan_beat_t pending_scans[$];
        bit         auto_release = 1'b1;
        int         failures = 0;
        int         beats_checked = 0;
        int         events_noted = 0;

        function void note_key_event(logic [KEY_W-1:0] key_in, logic [MOD_W-1:0] flags_in);
            logic [KEY_W-1:0] key;
            logic [MOD_W-1:0] flags;
            logic [KEY_W-1:0] sc [NUM_SLOTS];
            bit               on [NUM_SLOTS];
            bit               any_super;
            bit               do_press;
            bit               do_release;
            int               total;
            int               seen;
            scan_beat_t       beat;
            key = key_in;
            flags = flags_in;
            events_noted++;
            case (key[15:8])
                PFX_CTRL:  flags[MOD_CTRL] = 1'b1;
                PFX_SHIFT: flags[MOD_SHIFT] = 1'b1;
                PFX_ALT:   flags[MOD_ALT] = 1'b1;
                PFX_SUPER: flags[MOD_SUPER] = 1'b1;
                default:   ;
            endcase
            if (key == KEY_SYSRQ)
            begin
                if (flags[MOD_SHIFT] || flags[MOD_CTRL])
                begin
                    flags[MOD_SHIFT] = 1'b0;
                    flags[MOD_CTRL] = 1'b0;
                end
                else if (flags[MOD_ALT])
                begin
                    flags[MOD_ALT] = 1'b0;
                    key = KEY_ALT_SYSRQ;
                end
                else
                    flags[MOD_FAKE] = 1'b1;
            end
            else if (key == KEY_PAUSE && flags[MOD_CTRL])
            begin
                flags[MOD_CTRL] = 1'b0;
                key = KEY_CTRL_BRK;
            end
            any_super = flags[MOD_SUPER] | flags[MOD_HYPER] | flags[MOD_META];
            do_press = !(flags[MOD_UP] && !flags[MOD_DOWN]);
            do_release = auto_release || flags[MOD_UP];

            sc[SL_P_SUPER] = SC_SUPER;  on[SL_P_SUPER] = do_press && any_super;
            sc[SL_P_CTRL]  = SC_CTRL;   on[SL_P_CTRL]  = do_press && flags[MOD_CTRL];
            sc[SL_P_ALT]   = SC_ALT;    on[SL_P_ALT]   = do_press && flags[MOD_ALT];
            sc[SL_P_SHIFT] = SC_SHIFT;  on[SL_P_SHIFT] = do_press && flags[MOD_SHIFT];
            sc[SL_P_FAKE]  = SC_FAKE;   on[SL_P_FAKE]  = do_press && flags[MOD_FAKE];
            sc[SL_P_KEY]   = key;       on[SL_P_KEY]   = do_press && (key != '0);
            sc[SL_R_KEY]   = key;       on[SL_R_KEY]   = do_release && (key != '0);
            sc[SL_R_FAKE]  = SC_FAKE;   on[SL_R_FAKE]  = do_release && flags[MOD_FAKE];
            sc[SL_R_SHIFT] = SC_SHIFT;  on[SL_R_SHIFT] = do_release && flags[MOD_SHIFT];
            sc[SL_R_ALT]   = SC_ALT;    on[SL_R_ALT]   = do_release && flags[MOD_ALT];
            sc[SL_R_CTRL]  = SC_CTRL;   on[SL_R_CTRL]  = do_release && flags[MOD_CTRL];
            sc[SL_R_SUPER] = SC_SUPER;  on[SL_R_SUPER] = do_release && any_super;

            total = 0;
            for (int i = 0; i < NUM_SLOTS; i++)
                if (on[i])
                    total++;
            seen = 0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (on[i])
                begin
                    beat.is_press = (i < NUM_PRESS);
                    beat.scan_code = sc[i];
                    beat.last = (seen == total - 1);
                    pending_scans.push_back(beat);
                    seen++;
                end
            end
        endfunction

        function void check_scan_beat(bit is_press, logic [KEY_W-1:0] scan_code, bit last);
            scan_beat_t want;
            beats_checked++;
            if (pending_scans.size() == 0)
            begin
                $error("scan beat with nothing expected: is_press %0d scan_code %h last %0d",
                       is_press, scan_code, last);
                failures++;
                return;
            end
            want = pending_scans.pop_front();
            if (is_press !== want.is_press)
            begin
                $error("is_press: expected %0d, got %0d", want.is_press, is_press);
                failures++;
            end
            if (scan_code !== want.scan_code)
            begin
                $error("scan_code: expected %h, got %h", want.scan_code, scan_code);
                failures++;
            end
            if (last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, last);
                failures++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wen;
    logic        cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // key_code[15:0], modifier_flags[24:16], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // scan_code[15:0]
    logic        m_axis_tuser;   // is_press
    logic        m_axis_tlast;   // last

    scan_scoreboard sb = new();
    bit             send_idle = 1'b1;
    bit             recv_idle = 1'b1;
    bit             seen_auto_off = 1'b0;
    int             quiet_cycles = 0;

    key_event_scancode_sequencer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // beat monitor and hang watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_key_event(s_axis_tdata[15:0], s_axis_tdata[24:16]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_scan_beat(m_axis_tuser, m_axis_tdata, m_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles, %0d scan beats outstanding",
                         HANG_LIMIT, sb.pending_scans.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // scan code sink with random stalls
    initial
    begin
        int stall;
        m_axis_tready <= 1'b0;
        forever
        begin
            stall = recv_idle ? $urandom_range(0, STALL_MAX) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(rst_n && m_axis_tvalid));
        end
    end

    task automatic send_key(logic [KEY_W-1:0] key, logic [MOD_W-1:0] flags);
        int gap;
        gap = send_idle ? $urandom_range(0, STALL_MAX) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, flags, key};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // stop sending and wait for every expected scan beat, then let the block settle
    task automatic drain_runs();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_scans.size() > 0)
            @(posedge clk);
        repeat (QUIET_WAIT) @(posedge clk);
    endtask

    task automatic write_auto_release(bit value);
        drain_runs();
        cfg_wen <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        sb.auto_release = value;
        if (!value)
            seen_auto_off = 1'b1;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        logic [7:0] pfx;
        case ($urandom_range(0, 9))
            0: return KEY_SYSRQ;
            1: return KEY_PAUSE;
            2: return '0;
            3: return '1;
            4, 5:
            begin
                case ($urandom_range(0, 3))
                    0:       pfx = PFX_CTRL;
                    1:       pfx = PFX_SHIFT;
                    2:       pfx = PFX_ALT;
                    default: pfx = PFX_SUPER;
                endcase
                return {pfx, 8'($urandom)};
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [MOD_W-1:0] pick_flags();
        case ($urandom_range(0, 3))
            0:       return 9'b1 << $urandom_range(0, MOD_W - 1);
            1:       return 9'($urandom) & ~(F_UP | F_DOWN);
            default: return 9'($urandom);
        endcase
    endfunction

    initial
    begin
        rst_n <= 1'b0;
        cfg_wen <= 1'b0;
        cfg_wdata <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // auto release from reset
        send_key(16'h001e, '0);
        send_key('0, '0);
        send_key('1, F_ALL);
        send_key(KEY_SYSRQ, '0);
        send_key(KEY_SYSRQ, F_SHIFT);
        send_key(KEY_SYSRQ, F_CTRL);
        send_key(KEY_SYSRQ, F_ALT);
        send_key(KEY_SYSRQ, F_SHIFT | F_ALT);
        send_key(KEY_PAUSE, '0);
        send_key(KEY_PAUSE, F_CTRL);
        send_key({PFX_CTRL, 8'h00}, '0);
        send_key({PFX_SHIFT, 8'h10}, F_UP);
        send_key({PFX_ALT, 8'h45}, F_DOWN);
        send_key({PFX_SUPER, 8'h01}, F_UP | F_DOWN);
        send_key(16'h0030, F_HYPER);
        send_key(16'h0031, F_META | F_FAKE);
        send_key(16'he048, F_SUPER | F_CTRL | F_ALT | F_SHIFT);
        send_key('0, F_UP);
        send_key('0, F_SHIFT);

        // explicit key up only
        write_auto_release(1'b0);
        send_key(16'h001e, '0);
        send_key(16'h001e, F_UP);
        send_key('0, '0);
        send_key(KEY_SYSRQ, F_UP | F_DOWN);
        send_key(KEY_PAUSE, F_CTRL | F_UP);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            write_auto_release(phase[0]);
            send_idle = (phase % 4 == 0) || (phase % 4 == 2);
            recv_idle = (phase % 4 == 0) || (phase % 4 == 3);
            for (int n = 0; n < PHASE_LEN; n++)
                send_key(pick_key(), pick_flags());
        end

        drain_runs();
        $display("%0d key events sent over %0d phases, %0d scan beats checked",
                 sb.events_noted, NUM_PHASES + 2, sb.beats_checked);
        $display("auto release off and on both used: %0d, stalls on both sides mixed",
                 seen_auto_off);
        if (sb.failures == 0 && sb.pending_scans.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
